>>> hdl/iate_pkg.sv
// ----------------------------------------------------------------------------
// iate_pkg
// Shared types and constants for the integer array table engine: store
// geometry, request codes and result status codes.
// ----------------------------------------------------------------------------
package iate_pkg;

    // store geometry
    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int WORD_W = 32;

    // capacity register
    localparam int             CFG_W     = 7;
    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(DEPTH);

    // word returned on an error
    localparam logic signed [WORD_W-1:0] WORD_ERR = '1;

    // request codes
    typedef enum logic [2:0] {
        ACT_PUSH  = 3'd0,
        ACT_POP   = 3'd1,
        ACT_GET   = 3'd2,
        ACT_SET   = 3'd3,
        ACT_DEL   = 3'd4,
        ACT_INS   = 3'd5,
        ACT_HAS   = 3'd6,
        ACT_CLEAR = 3'd7
    } t_action;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

>>> hdl/iate_if.sv
// ----------------------------------------------------------------------------
// iate_if
// Valid/ready channels of the integer array table engine: request,
// response and capacity write.
// ----------------------------------------------------------------------------

// request channel
interface iate_req_if;
    logic                                 valid;
    logic                                 ready;
    iate_pkg::t_action                    action;
    logic signed [iate_pkg::WORD_W-1:0]   value;
    logic        [iate_pkg::ADDR_W-1:0]   index;

    modport source (output valid, output action, output value, output index, input ready);
    modport sink   (input valid, input action, input value, input index, output ready);
endinterface

// response channel
interface iate_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [iate_pkg::WORD_W-1:0]   data;
    iate_pkg::t_status                    status;
    logic                                 found;
    logic                                 empty_res;
    logic        [iate_pkg::CNT_W-1:0]    count;

    modport source (output valid, output data, output status, output found,
                    output empty_res, output count, input ready);
    modport sink   (input valid, input data, input status, input found,
                    input empty_res, input count, output ready);
endinterface

// capacity write channel
interface iate_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic        [iate_pkg::CFG_W-1:0]    capacity_limit;

    modport source (output valid, output capacity_limit, input ready);
    modport sink   (input valid, input capacity_limit, output ready);
endinterface

>>> hdl/integer_array_table_engine.sv
// ----------------------------------------------------------------------------
// integer_array_table_engine
// Bounded array of signed words with push, pop, get, set, delete, sorted
// unique insert, membership test and clear, one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request (action, value, index); o_rsp returns one
//   response (data, status, found, empty_res, count) per request, in order.
//   i_cfg writes the capacity limit; it is always ready and is meant to be
//   written only while no request is in flight.
// Sequence per request, one request at a time:
//   push, set, clear and error cases go straight to the output state;
//   pop and get pass through the read state; contains scans the filled
//   entries, one entry per cycle, and stops at the first match; delete
//   reads the deleted word, then moves each entry above it down one place;
//   insert scans for the position and, unless the word lands last or is
//   refused, shifts the entries at and above its position up one place, from
//   the top down, then places the word. The next request is taken the cycle after the response is loaded.
//   The store is a single memory with one read and one write port and a
//   registered read; the scan and shift walks are bound by that port pair.
// Reset: the fill count and all entry valid bits clear and the capacity
//   returns to 64 at once, so the block takes requests as soon as reset is released.
// Stall: the response is held in an output register; the engine finishes
//   the next request and waits until that register is taken.
// ----------------------------------------------------------------------------
module integer_array_table_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iate_req_if.sink   i_req,
    iate_rsp_if.source o_rsp,
    iate_cfg_if.sink   i_cfg
);

    localparam int AW = iate_pkg::ADDR_W;
    localparam int CW = iate_pkg::CNT_W;
    localparam int WW = iate_pkg::WORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_DEL_HEAD,
        S_DEL_SHIFT,
        S_INS_SHIFT,
        S_INS_PUT,
        S_OUT
    } t_state;

    // control registers
    t_state                    r_state, n_state;
    logic [CW-1:0]             r_cnt, n_cnt;
    logic [iate_pkg::CFG_W-1:0] r_cap;
    logic [iate_pkg::DEPTH-1:0] r_vld, n_vld;
    logic [CW-1:0]             r_ptr, n_ptr;
    logic [CW-1:0]             r_pos, n_pos;
    logic                      r_pend, n_pend;
    logic                      r_ovld;

    // request and result registers
    iate_pkg::t_action         r_act, n_act;
    logic signed [WW-1:0]      r_value, n_value;
    logic signed [WW-1:0]      r_res_data, n_res_data;
    iate_pkg::t_status         r_res_status, n_res_status;
    logic                      r_res_found, n_res_found;
    logic signed [WW-1:0]      r_o_data;
    iate_pkg::t_status         r_o_status;
    logic                      r_o_found;
    logic                      r_o_empty;
    logic [CW-1:0]             r_o_count;

    // memory
    logic [WW-1:0]             r_mem [iate_pkg::DEPTH];
    logic [WW-1:0]             r_rdata;
    logic                      r_rvld;

    // memory port controls
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [WW-1:0]             w_wdata;
    logic                      w_re;
    logic [AW-1:0]             w_raddr;

    logic                      w_req_xfer;
    logic                      w_load;
    logic [CW-1:0]             w_cap;
    logic                      w_full;
    logic signed [WW-1:0]      w_rword;
    logic                      w_hit;
    logic                      w_ins_end;
    logic                      w_dup;
    logic [CW-1:0]             w_pos;

    // handshakes
    assign i_req.ready = i_rst_n && (r_state == S_IDLE);
    assign i_cfg.ready = i_rst_n;
    assign w_req_xfer  = i_req.valid && i_req.ready;
    assign w_load      = (r_state == S_OUT) && (!r_ovld || o_rsp.ready);

    // usable capacity: zero acts as one, above the depth acts as the depth
    always_comb begin
        if (r_cap == '0) begin
            w_cap = CW'(1);
        end else if (CW'(r_cap) > CW'(iate_pkg::DEPTH)) begin
            w_cap = CW'(iate_pkg::DEPTH);
        end else begin
            w_cap = CW'(r_cap);
        end
    end

    assign w_full  = (r_cnt >= w_cap);
    assign w_rword = r_rvld ? $signed(r_rdata) : '0;

    // scan compare against the word in flight
    always_comb begin
        if (r_act == iate_pkg::ACT_HAS) begin
            w_hit = r_pend && (w_rword == r_value);
        end else begin
            w_hit = r_pend && (r_value <= w_rword);
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_vld        = r_vld;
        n_ptr        = r_ptr;
        n_pos        = r_pos;
        n_pend       = r_pend;
        n_act        = r_act;
        n_value      = r_value;
        n_res_data   = r_res_data;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        w_we         = 1'b0;
        w_waddr      = r_ptr[AW-1:0];
        w_wdata      = r_value;
        w_re         = 1'b0;
        w_raddr      = r_ptr[AW-1:0];
        w_ins_end    = 1'b0;
        w_dup        = 1'b0;
        w_pos        = r_cnt;

        case (r_state)
            S_IDLE: begin
                if (w_req_xfer) begin
                    n_act        = i_req.action;
                    n_value      = i_req.value;
                    n_res_data   = '0;
                    n_res_status = iate_pkg::ST_OK;
                    n_res_found  = 1'b0;
                    n_ptr        = '0;
                    n_pend       = 1'b0;
                    n_state      = S_OUT;
                    case (i_req.action)
                        iate_pkg::ACT_PUSH: begin
                            if (w_full) begin
                                n_res_status = iate_pkg::ST_FULL;
                                n_res_data   = iate_pkg::WORD_ERR;
                            end else begin
                                w_we           = 1'b1;
                                w_waddr        = r_cnt[AW-1:0];
                                w_wdata        = i_req.value;
                                n_vld[w_waddr] = 1'b1;
                                n_cnt          = r_cnt + CW'(1);
                            end
                        end
                        iate_pkg::ACT_POP: begin
                            if (r_cnt == '0) begin
                                n_res_status = iate_pkg::ST_RANGE;
                                n_res_data   = iate_pkg::WORD_ERR;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(r_cnt - CW'(1));
                                n_cnt   = r_cnt - CW'(1);
                                n_state = S_READ;
                            end
                        end
                        iate_pkg::ACT_GET: begin
                            if (CW'(i_req.index) >= w_cap) begin
                                n_res_status = iate_pkg::ST_RANGE;
                                n_res_data   = iate_pkg::WORD_ERR;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = i_req.index;
                                n_state = S_READ;
                            end
                        end
                        iate_pkg::ACT_SET: begin
                            if (CW'(i_req.index) >= w_cap) begin
                                n_res_status = iate_pkg::ST_RANGE;
                                n_res_data   = iate_pkg::WORD_ERR;
                            end else begin
                                w_we           = 1'b1;
                                w_waddr        = i_req.index;
                                w_wdata        = i_req.value;
                                n_vld[w_waddr] = 1'b1;
                            end
                        end
                        iate_pkg::ACT_DEL: begin
                            if (CW'(i_req.index) >= r_cnt) begin
                                n_res_status = iate_pkg::ST_RANGE;
                                n_res_data   = iate_pkg::WORD_ERR;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = i_req.index;
                                n_ptr   = CW'(i_req.index);
                                n_state = S_DEL_HEAD;
                            end
                        end
                        iate_pkg::ACT_INS, iate_pkg::ACT_HAS: begin
                            n_state = S_SCAN;
                        end
                        iate_pkg::ACT_CLEAR: begin
                            n_vld = '0;
                            n_cnt = '0;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            // single read result
            S_READ: begin
                n_res_data = w_rword;
                n_state    = S_OUT;
            end

            // walk the filled entries, one read issued per cycle
            S_SCAN: begin
                if (w_hit) begin
                    if (r_act == iate_pkg::ACT_HAS) begin
                        n_res_found = 1'b1;
                        n_state     = S_OUT;
                    end else begin
                        w_ins_end = 1'b1;
                        w_dup     = (w_rword == r_value);
                        w_pos     = r_ptr - CW'(1);
                    end
                end else if (r_ptr < r_cnt) begin
                    w_re   = 1'b1;
                    n_ptr  = r_ptr + CW'(1);
                    n_pend = 1'b1;
                end else if (r_act == iate_pkg::ACT_HAS) begin
                    n_state = S_OUT;
                end else begin
                    w_ins_end = 1'b1;
                    w_pos     = r_cnt;
                end

                // insert decision once the position is known
                if (w_ins_end) begin
                    n_pos   = w_pos;
                    n_state = S_OUT;
                    if (w_dup) begin
                        n_res_status = iate_pkg::ST_DUP;
                    end else if (w_full) begin
                        n_res_status = iate_pkg::ST_FULL;
                        n_res_data   = iate_pkg::WORD_ERR;
                    end else if (r_cnt == w_pos) begin
                        w_we           = 1'b1;
                        w_waddr        = w_pos[AW-1:0];
                        n_vld[w_waddr] = 1'b1;
                        n_cnt          = r_cnt + CW'(1);
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = AW'(r_cnt - CW'(1));
                        n_ptr   = r_cnt;
                        n_state = S_INS_SHIFT;
                    end
                end
            end

            // move one entry up per cycle, from the top down
            S_INS_SHIFT: begin
                w_we           = 1'b1;
                w_wdata        = w_rword;
                n_vld[w_waddr] = 1'b1;
                n_ptr          = r_ptr - CW'(1);
                if ((r_ptr - CW'(1)) > r_pos) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_ptr - CW'(2));
                end else begin
                    n_state = S_INS_PUT;
                end
            end

            // place the new word at its position
            S_INS_PUT: begin
                w_we           = 1'b1;
                w_waddr        = r_pos[AW-1:0];
                n_vld[w_waddr] = 1'b1;
                n_cnt          = r_cnt + CW'(1);
                n_state        = S_OUT;
            end

            // deleted word arrives; start the left shift, or free the slot if it was the top entry
            S_DEL_HEAD: begin
                n_res_data = w_rword;
                if ((r_ptr + CW'(1)) < r_cnt) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_ptr + CW'(1));
                    n_state = S_DEL_SHIFT;
                end else begin
                    n_vld[r_ptr[AW-1:0]] = 1'b0;
                    n_cnt                = r_cnt - CW'(1);
                    n_state              = S_OUT;
                end
            end

            // move one entry down per cycle, invalidate the freed top slot
            S_DEL_SHIFT: begin
                w_we           = 1'b1;
                w_wdata        = w_rword;
                n_vld[w_waddr] = 1'b1;
                if ((r_ptr + CW'(2)) < r_cnt) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_ptr + CW'(2));
                    n_ptr   = r_ptr + CW'(1);
                end else begin
                    n_vld[AW'(r_cnt - CW'(1))] = 1'b0;
                    n_cnt                      = r_cnt - CW'(1);
                    n_state                    = S_OUT;
                end
            end

            // hand the result to the output register
            S_OUT: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cap   <= iate_pkg::CAP_RESET;
            r_vld   <= '0;
            r_ptr   <= '0;
            r_pos   <= '0;
            r_pend  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_vld   <= n_vld;
            r_ptr   <= n_ptr;
            r_pos   <= n_pos;
            r_pend  <= n_pend;
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.capacity_limit;
            end
            if (w_load) begin
                r_ovld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
        end
        r_act        <= n_act;
        r_value      <= n_value;
        r_res_data   <= n_res_data;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        if (w_load) begin
            r_o_data   <= r_res_data;
            r_o_status <= r_res_status;
            r_o_found  <= r_res_found;
            r_o_empty  <= (r_cnt == '0);
            r_o_count  <= r_cnt;
        end
    end

    // entry memory, read-first, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
            r_rvld  <= r_vld[w_raddr];
        end
    end

    // response outputs
    assign o_rsp.valid     = r_ovld;
    assign o_rsp.data      = r_o_data;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.found     = r_o_found;
    assign o_rsp.empty_res = r_o_empty;
    assign o_rsp.count     = r_o_count;

    // fill count stays within the store
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(iate_pkg::DEPTH))
        else $error("fill count beyond store depth");

    // shift walks never read and write the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("read and write to the same entry in one cycle");

    // one request at a time: a transfer closes the request channel
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_xfer |=> !i_req.ready)
        else $error("request taken while another is in flight");

    // a scan read is in flight only during a scan
    a_pend_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && w_re) |=> (r_pend && r_state != S_IDLE))
        else $error("scan read lost");

endmodule

>>> bench/tb_integer_array_table_engine.sv
// ----------------------------------------------------------------------------
// tb_integer_array_table_engine
// Self-checking bench for the integer array table engine. A shadow copy of
// the word store, fill count and capacity register predicts every response.
// A short table of directed requests runs first, with hand-written responses
// where they are obvious. Random request streams follow, one per capacity
// setting, with random idle and stall on both channels in the first six.
// ----------------------------------------------------------------------------
module tb_integer_array_table_engine;
    import iate_pkg::*;

    localparam int PERIOD     = 10;
    localparam int RST_CYCLES = 9;
    localparam int SETTLE     = 2 * DEPTH + 16;  // longest insert walk plus margin
    localparam int STALL_MAX  = 4000;            // cycles without any transfer
    localparam int N_PHASES   = 9;
    localparam int PHASE_LEN  = 120;

    // one response as seen on the output channel
    typedef struct packed {
        logic signed [WORD_W-1:0] data;
        t_status                  status;
        logic                     found;
        logic                     empty_res;
        logic [CNT_W-1:0]         count;
    } t_result;

    // one directed request, with its response when it is written out by hand
    typedef struct packed {
        t_action                  act;
        logic signed [WORD_W-1:0] val;
        logic [ADDR_W-1:0]        idx;
        logic                     typed;
        t_result                  want;
    } t_row;

    localparam logic signed [WORD_W-1:0] W_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] W_MIN = 32'sh8000_0000;
    localparam t_result ANY = '0;

    localparam int N_DIRECTED = 25;
    localparam t_row DIRECTED [N_DIRECTED] = '{
        // empty store after reset
        '{ACT_POP,   32'sd0, 6'd0,  1'b1, '{WORD_ERR, ST_RANGE, 1'b0, 1'b1, 7'd0}},
        '{ACT_GET,   32'sd0, 6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b1, 7'd0}},
        '{ACT_GET,   32'sd0, 6'd63, 1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b1, 7'd0}},
        '{ACT_DEL,   32'sd0, 6'd0,  1'b1, '{WORD_ERR, ST_RANGE, 1'b0, 1'b1, 7'd0}},
        '{ACT_HAS,   32'sd0, 6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b1, 7'd0}},
        // set past fill leaves the count alone, get past fill reads the slot
        '{ACT_SET,   W_MAX,  6'd63, 1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b1, 7'd0}},
        '{ACT_GET,   32'sd0, 6'd63, 1'b1, '{W_MAX,    ST_OK,    1'b0, 1'b1, 7'd0}},
        // extremes of the word
        '{ACT_PUSH,  W_MIN,  6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b0, 7'd1}},
        '{ACT_PUSH,  W_MAX,  6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b0, 7'd2}},
        '{ACT_HAS,   W_MAX,  6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b1, 1'b0, 7'd2}},
        '{ACT_HAS,   32'sd0, 6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b0, 7'd2}},
        '{ACT_POP,   32'sd0, 6'd0,  1'b1, '{W_MAX,    ST_OK,    1'b0, 1'b0, 7'd1}},
        // clear wipes every slot
        '{ACT_CLEAR, 32'sd0, 6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b1, 7'd0}},
        '{ACT_GET,   32'sd0, 6'd63, 1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b1, 7'd0}},
        // sorted insert, front, back and duplicate
        '{ACT_INS,   32'sd5, 6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b0, 7'd1}},
        '{ACT_INS,   -32'sd3, 6'd0, 1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b0, 7'd2}},
        '{ACT_INS,   W_MAX,  6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b0, 7'd3}},
        '{ACT_INS,   W_MIN,  6'd0,  1'b1, '{32'sd0,   ST_OK,    1'b0, 1'b0, 7'd4}},
        '{ACT_INS,   32'sd5, 6'd0,  1'b1, '{32'sd0,   ST_DUP,   1'b0, 1'b0, 7'd4}},
        '{ACT_INS,   32'sd0, 6'd0,  1'b0, ANY},
        // delete in the middle, at the end, then past the fill
        '{ACT_DEL,   32'sd0, 6'd1,  1'b0, ANY},
        '{ACT_DEL,   32'sd0, 6'd3,  1'b0, ANY},
        '{ACT_DEL,   32'sd0, 6'd3,  1'b1, '{WORD_ERR, ST_RANGE, 1'b0, 1'b0, 7'd3}},
        '{ACT_GET,   32'sd0, 6'd3,  1'b0, ANY},
        '{ACT_HAS,   32'sd5, 6'd0,  1'b0, ANY}
    };

    // capacity and push/insert share per random phase
    localparam int PHASE_CAP  [N_PHASES] = '{0, 1, 2, 127, 5, 64, 3, 100, 64};
    localparam int PHASE_GROW [N_PHASES] = '{55, 55, 60, 75, 55, 75, 55, 75, 45};

    logic i_clk = 1'b0;
    logic i_rst_n;

    iate_req_if req_ch ();
    iate_rsp_if rsp_ch ();
    iate_cfg_if cfg_ch ();

    integer_array_table_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #(PERIOD / 2) i_clk = ~i_clk;

    // shadow of the block state
    logic signed [WORD_W-1:0] store_words [DEPTH];
    int                       fill_cnt;
    logic [CFG_W-1:0]         cap_reg;

    t_result owed_responses [$];
    int      err_count    = 0;
    int      rsp_seen     = 0;
    int      feed_idle_pct;
    int      take_idle_pct;
    int      quiet_cycles = 0;

    task automatic report_mismatch(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // apply one request to the shadow store and return its response
    function automatic t_result apply_request(input t_action act,
                                              input logic signed [WORD_W-1:0] val,
                                              input logic [ADDR_W-1:0] idx);
        t_result r;
        int      usable;
        int      pos;
        int      i;
        bit      dup;

        usable = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : int'(cap_reg));
        r      = '0;
        r.status = ST_OK;
        pos    = 0;
        dup    = 1'b0;
        case (act)
            ACT_PUSH: begin
                if (fill_cnt >= usable) begin
                    r.status = ST_FULL;
                    r.data   = WORD_ERR;
                end else begin
                    store_words[fill_cnt] = val;
                    fill_cnt++;
                end
            end
            ACT_POP: begin
                if (fill_cnt == 0) begin
                    r.status = ST_RANGE;
                    r.data   = WORD_ERR;
                end else begin
                    fill_cnt--;
                    r.data = store_words[fill_cnt];
                end
            end
            ACT_GET: begin
                if (idx >= usable) begin
                    r.status = ST_RANGE;
                    r.data   = WORD_ERR;
                end else begin
                    r.data = store_words[idx];
                end
            end
            ACT_SET: begin
                if (idx >= usable) begin
                    r.status = ST_RANGE;
                    r.data   = WORD_ERR;
                end else begin
                    store_words[idx] = val;
                end
            end
            ACT_DEL: begin
                if (idx >= fill_cnt) begin
                    r.status = ST_RANGE;
                    r.data   = WORD_ERR;
                end else begin
                    r.data = store_words[idx];
                    for (i = idx; i + 1 < fill_cnt; i++)
                        store_words[i] = store_words[i + 1];
                    store_words[fill_cnt - 1] = '0;
                    fill_cnt--;
                end
            end
            ACT_INS: begin
                // duplicate check wins over full
                while (pos < fill_cnt && val > store_words[pos])
                    pos++;
                dup = (pos < fill_cnt) && (val == store_words[pos]);
                if (dup) begin
                    r.status = ST_DUP;
                end else if (fill_cnt >= usable) begin
                    r.status = ST_FULL;
                    r.data   = WORD_ERR;
                end else begin
                    for (i = fill_cnt; i > pos; i--)
                        store_words[i] = store_words[i - 1];
                    store_words[pos] = val;
                    fill_cnt++;
                end
            end
            ACT_HAS: begin
                for (i = 0; i < fill_cnt; i++)
                    if (store_words[i] == val)
                        r.found = 1'b1;
            end
            default: begin
                for (i = 0; i < DEPTH; i++)
                    store_words[i] = '0;
                fill_cnt = 0;
            end
        endcase
        r.empty_res = (fill_cnt == 0);
        r.count     = fill_cnt[CNT_W-1:0];
        return r;
    endfunction

    // one request transfer, with a random idle gap ahead of it
    task automatic send_request(input t_action act, input logic signed [WORD_W-1:0] val,
                                input logic [ADDR_W-1:0] idx, input logic typed,
                                input t_result want);
        t_result r;

        while ($urandom_range(0, 99) < feed_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= val;
        req_ch.index  <= idx;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
        r = apply_request(act, val, idx);
        owed_responses.push_back(typed ? want : r);
    endtask

    // hold requests back until every owed response has arrived
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (owed_responses.size() != 0)
            @(posedge i_clk);
    endtask

    // capacity write on an idle block
    task automatic write_capacity(input logic [CFG_W-1:0] cap);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.capacity_limit <= cap;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        cap_reg = cap;
    endtask

    task automatic check_response();
        t_result got;
        t_result want;

        got.data      = rsp_ch.data;
        got.status    = rsp_ch.status;
        got.found     = rsp_ch.found;
        got.empty_res = rsp_ch.empty_res;
        got.count     = rsp_ch.count;
        rsp_seen++;
        if (owed_responses.size() == 0) begin
            report_mismatch($sformatf("response %0d with none owed", rsp_seen));
        end else begin
            want = owed_responses.pop_front();
            if (got.data !== want.data)
                report_mismatch($sformatf("response %0d data %0d, want %0d",
                                          rsp_seen, got.data, want.data));
            if (got.status !== want.status)
                report_mismatch($sformatf("response %0d status %0d, want %0d",
                                          rsp_seen, got.status, want.status));
            if (got.found !== want.found)
                report_mismatch($sformatf("response %0d found %b, want %b",
                                          rsp_seen, got.found, want.found));
            if (got.empty_res !== want.empty_res)
                report_mismatch($sformatf("response %0d empty_res %b, want %b",
                                          rsp_seen, got.empty_res, want.empty_res));
            if (got.count !== want.count)
                report_mismatch($sformatf("response %0d count %0d, want %0d",
                                          rsp_seen, got.count, want.count));
        end
    endtask

    // response side: check each transfer, then pick the next ready at random
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
                check_response();
            rsp_ch.ready <= ($urandom_range(0, 99) >= take_idle_pct);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_MAX) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("[integer_array_table_engine] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int                       p;
        int                       k;
        int                       r;
        t_action                  act;
        logic signed [WORD_W-1:0] val;
        logic [ADDR_W-1:0]        idx;

        fill_cnt      = 0;
        cap_reg       = CAP_RESET;
        feed_idle_pct = 28;
        take_idle_pct = 48;
        for (k = 0; k < DEPTH; k++)
            store_words[k] = '0;

        i_rst_n               <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.action         <= ACT_PUSH;
        req_ch.value          <= '0;
        req_ch.index          <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.capacity_limit <= CAP_RESET;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset capacity
        for (k = 0; k < N_DIRECTED; k++)
            send_request(DIRECTED[k].act, DIRECTED[k].val, DIRECTED[k].idx,
                         DIRECTED[k].typed, DIRECTED[k].want);

        // random phases, one capacity each; store contents carry over
        for (p = 0; p < N_PHASES; p++) begin
            write_capacity(CFG_W'(PHASE_CAP[p]));
            feed_idle_pct = (p < 3) ? 28 : ((p < 6) ? 48 : 0);
            take_idle_pct = (p < 3) ? 48 : ((p < 6) ? 28 : 0);
            for (k = 0; k < PHASE_LEN; k++) begin
                // now and then let the block run dry
                if ($urandom_range(0, 49) == 0)
                    wait_drained();

                r = $urandom_range(0, 99);
                if (r < PHASE_GROW[p]) begin
                    act = r[0] ? ACT_PUSH : ACT_INS;
                end else begin
                    r = $urandom_range(0, 29);
                    if (r < 6)       act = ACT_POP;
                    else if (r < 12) act = ACT_GET;
                    else if (r < 17) act = ACT_SET;
                    else if (r < 23) act = ACT_DEL;
                    else if (r < 29) act = ACT_HAS;
                    else             act = ACT_CLEAR;
                end

                // small words collide often, held words hit contains and duplicates
                r = $urandom_range(0, 9);
                if (r < 4)
                    val = $signed($urandom_range(0, 16)) - 32'sd8;
                else if (r == 4)
                    case ($urandom_range(0, 3))
                        0:       val = W_MIN;
                        1:       val = W_MAX;
                        2:       val = -32'sd1;
                        default: val = 32'sd0;
                    endcase
                else if (r == 5 && fill_cnt > 0)
                    val = store_words[$urandom_range(0, fill_cnt - 1)];
                else
                    val = $urandom;

                if ($urandom_range(0, 1) || fill_cnt == 0)
                    idx = ADDR_W'($urandom_range(0, DEPTH - 1));
                else
                    idx = ADDR_W'($urandom_range(0, fill_cnt - 1));

                send_request(act, val, idx, 1'b0, ANY);
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (err_count == 0)
            $display("[integer_array_table_engine] OK");
        else
            $display("[integer_array_table_engine] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hdl/iate_pkg.sv
hdl/iate_if.sv
hdl/integer_array_table_engine.sv
bench/tb_integer_array_table_engine.sv
